FILE: hdl/cursor_linked_list_manager_assert.svh
`ifndef CURSOR_LINKED_LIST_MANAGER_ASSERT_SVH
`define CURSOR_LINKED_LIST_MANAGER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CLM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor list manager check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor list manager check failed");

`endif

FILE: hdl/clm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clm_pkg;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  typedef struct packed {
    logic       clr_wr;
    logic       load_in;
    logic       a_rd;
    logic       a_wr1;
    logic       a_wr2;
    logic       walk_init;
    logic       d_rd;
    logic       d_adv;
    logic       d_unl;
    logic       d_free;
    logic       set_res;
    logic [1:0] res_code;
    logic       out_load;
  } clm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op;
    logic full;
    logic zero_val;
    logic walk_ok;
    logic match;
    logic count_zero;
    logic out_free;
  } clm_stat_t;

endpackage

`default_nettype wire

FILE: hdl/clm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module clm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  clm_pkg::clm_stat_t stat,
  output clm_pkg::clm_cmd_t  cmd
);
  import clm_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_A_WR1  = 4'd3;
  localparam logic [3:0] S_A_WR2  = 4'd4;
  localparam logic [3:0] S_D_TEST = 4'd5;
  localparam logic [3:0] S_D_CMP  = 4'd6;
  localparam logic [3:0] S_D_UNL  = 4'd7;
  localparam logic [3:0] S_D_FREE = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op == OP_APPEND) begin
          if (stat.full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_FULL;
            state_next   = S_FIN;
          end else begin
            cmd.a_rd   = 1'b1;
            state_next = S_A_WR1;
          end
        end else if (stat.zero_val) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_IGNORED;
          state_next   = S_FIN;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_D_TEST;
        end
      end
      S_A_WR1: begin
        cmd.a_wr1  = 1'b1;
        state_next = S_A_WR2;
      end
      S_A_WR2: begin
        cmd.a_wr2  = 1'b1;
        state_next = S_FIN;
      end
      S_D_TEST: begin
        if (stat.walk_ok) begin
          cmd.d_rd   = 1'b1;
          state_next = S_D_CMP;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
          state_next   = S_FIN;
        end
      end
      S_D_CMP: begin
        if (stat.match) begin
          if (stat.count_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOT_FOUND;
            state_next   = S_FIN;
          end else begin
            state_next = S_D_UNL;
          end
        end else begin
          cmd.d_adv  = 1'b1;
          state_next = S_D_TEST;
        end
      end
      S_D_UNL: begin
        cmd.d_unl  = 1'b1;
        state_next = S_D_FREE;
      end
      S_D_FREE: begin
        cmd.d_free = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/clm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module clm_dpath #(
  parameter int SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  input  clm_pkg::clm_cmd_t  cmd,
  output clm_pkg::clm_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [4:0]         out_slot,
  output logic [4:0]         out_len
);
  import clm_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS + 1);

  function automatic logic usable(input logic [IW-1:0] idx);
    return (idx != '0) && (idx < IW'(SLOTS - 1));
  endfunction

  logic signed [31:0] val_mem [SLOTS];
  logic [IW-1:0]      nxt_mem [SLOTS];

  // Control state.
  logic [IW-1:0] free_head;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [IW-1:0] cnt;
  logic [IW-1:0] clr_cnt;

  // Working registers of the current word.
  logic               op_r;
  logic signed [31:0] val_r;
  logic [IW-1:0]      aslot;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      prev;
  logic [SW-1:0]      steps;
  logic signed [31:0] rd_val;
  logic [IW-1:0]      rd_next;
  logic [1:0]         res_status;
  logic [IW-1:0]      res_slot;

  logic               link;
  logic [IW-1:0]      nxt_s;
  logic [IW-1:0]      fh_s;
  logic [IW-1:0]      cnt_dec;
  logic [IW-1:0]      chain;
  logic [IW+4:0]      slot_ext;
  logic [IW+4:0]      len_ext;

  logic               n_we;
  logic [IW-1:0]      n_wa;
  logic [IW-1:0]      n_wd;
  logic               n_re;
  logic [IW-1:0]      n_ra;
  logic               v_we;
  logic [IW-1:0]      v_wa;
  logic signed [31:0] v_wd;

  assign link     = (cnt != '0) && usable(tail);
  assign nxt_s    = usable(rd_next) ? rd_next : '0;
  assign fh_s     = usable(free_head) ? free_head : '0;
  assign cnt_dec  = cnt - 1'b1;
  assign chain    = (clr_cnt < IW'(SLOTS - 2)) ? clr_cnt + 1'b1 : '0;
  assign slot_ext = {5'd0, res_slot};
  assign len_ext  = {5'd0, cnt};

  assign stat.clr_last   = (clr_cnt == IW'(SLOTS - 1));
  assign stat.op         = op_r;
  assign stat.full       = !usable(free_head);
  assign stat.zero_val   = (val_r == 32'sd0);
  assign stat.walk_ok    = usable(cur) && (steps < SW'(SLOTS));
  assign stat.match      = (rd_val == val_r);
  assign stat.count_zero = (cnt == '0);
  assign stat.out_free   = !out_valid || out_ready;

  assign n_re = cmd.a_rd || cmd.d_rd;
  assign n_ra = cmd.a_rd ? free_head : cur;

  always_comb begin
    n_we = 1'b0;
    n_wa = '0;
    n_wd = '0;
    if (cmd.clr_wr) begin
      n_we = 1'b1;
      n_wa = clr_cnt;
      n_wd = chain;
    end else if (cmd.a_wr1) begin
      n_we = 1'b1;
      n_wa = aslot;
    end else if (cmd.a_wr2 && link) begin
      n_we = 1'b1;
      n_wa = tail;
      n_wd = aslot;
    end else if (cmd.d_unl && (prev != '0)) begin
      n_we = 1'b1;
      n_wa = prev;
      n_wd = nxt_s;
    end else if (cmd.d_free) begin
      n_we = 1'b1;
      n_wa = cur;
      n_wd = fh_s;
    end
  end

  always_comb begin
    v_we = 1'b0;
    v_wa = '0;
    v_wd = '0;
    if (cmd.clr_wr) begin
      v_we = 1'b1;
      v_wa = clr_cnt;
    end else if (cmd.a_wr1) begin
      v_we = 1'b1;
      v_wa = aslot;
      v_wd = val_r;
    end else if (cmd.d_unl) begin
      v_we = 1'b1;
      v_wa = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      val_mem[v_wa] <= v_wd;
    end
    if (cmd.d_rd) begin
      rd_val <= val_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nxt_mem[n_wa] <= n_wd;
    end
    if (n_re) begin
      rd_next <= nxt_mem[n_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= IW'(1);
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.a_wr1) begin
        free_head <= nxt_s;
      end
      if (cmd.a_wr2) begin
        if (!link) begin
          head <= aslot;
        end
        tail <= aslot;
        cnt  <= cnt + 1'b1;
      end
      if (cmd.d_unl) begin
        cnt <= cnt_dec;
        // Emptying the list clears both ends whatever the unlink chose.
        if (cnt_dec == '0) begin
          head <= '0;
          tail <= '0;
        end else begin
          if (prev == '0) begin
            head <= nxt_s;
          end
          if (cur == tail) begin
            tail <= prev;
          end
        end
      end
      if (cmd.d_free) begin
        free_head <= cur;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      val_r <= in_value;
    end
    if (cmd.a_rd) begin
      aslot <= free_head;
    end
    if (cmd.walk_init) begin
      cur   <= head;
      prev  <= '0;
      steps <= '0;
    end
    if (cmd.d_adv) begin
      prev  <= cur;
      cur   <= rd_next;
      steps <= steps + 1'b1;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_slot   <= '0;
    end
    if (cmd.a_wr2) begin
      res_status <= ST_DONE;
      res_slot   <= aslot;
    end
    if (cmd.d_free) begin
      res_status <= ST_DONE;
      res_slot   <= cur;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= slot_ext[4:0];
      out_len    <= len_ext[4:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cursor_linked_list_manager.sv
// Channel  Direction  Contents
// s_*      in         tdata: value (32, signed); tuser: opcode (1)
// m_*      out        tdata: status (2), slot_index (5), list_length (5), zero pad (4)
//
// An append reads a free slot, writes the new node and then links it at the tail;
// a full store or a zero delete goes straight from dispatch to its result. A delete
// walks the list and reads each node from the registered memory ports.
// After reset a clearing pass writes every entry of the slot store and no word is
// accepted until it ends. A new word is taken while the previous result waits in the
// output register; a result stalls in its final state until that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_linked_list_manager_assert.svh"

module cursor_linked_list_manager #(
  parameter int SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic signed [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]         s_tuser,   // [0] opcode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata    // [1:0] status, [6:2] slot_index, [11:7] list_length
);
  import clm_pkg::*;

  clm_cmd_t   cmd;
  clm_stat_t  stat;
  logic [1:0] out_status;
  logic [4:0] out_slot;
  logic [4:0] out_len;

  clm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clm_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_tuser[0]),
    .in_value   (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_len    (out_len)
  );

  assign m_tdata = {4'd0, out_len, out_slot, out_status};

  // The block is busy with a word for at least the cycle after taking it.
  `CLM_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)
  // A result is only loaded when the output register is free.
  `CLM_ASSERT_NOW(a_load_when_free, clk, rst, cmd.out_load, !m_tvalid || m_tready)
  // The clearing pass holds off input straight after reset.
  `CLM_ASSERT_NOW(a_clear_after_reset, clk, rst, $past(rst), !s_tready)

endmodule

`default_nettype wire

FILE: tb/cursor_linked_list_manager_tb.sv
`timescale 1ns / 1ps

module cursor_linked_list_manager_tb;
  import clm_pkg::*;

  localparam int SLOTS        = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int LONG_HOLD_AT = 800;
  localparam int RANDOM_WORDS = 1930;
  localparam int ZERO_TAIL_AT = 1850;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    logic [4:0] len;
  } list_result_t;

  typedef struct {
    logic         op;
    logic [31:0]  value;
    bit           known;
    list_result_t want;
  } list_word_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] value
  logic [0:0]  s_tuser  = '0;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [1:0] status, [6:2] slot_index, [11:7] list_length

  // Shadow copy of the slot store.
  logic [31:0] slot_value [SLOTS];
  logic [4:0]  slot_link  [SLOTS];
  logic [4:0]  lst_head;
  logic [4:0]  lst_tail;
  logic [4:0]  lst_count;

  list_word_t   offered_words [$];
  list_result_t want_results  [$];
  list_word_t   directed_words[$];

  int       n_sent      = 0;
  int       n_results   = 0;
  int       n_errors    = 0;
  int       cycle_count = 0;
  int       burst_left  = 0;
  bit       long_hold_req  = 1'b0;
  bit       long_hold_done = 1'b0;
  int       hold_left   = 0;
  int       rx_left     = 0;
  rx_mode_t rx_mode     = RX_OPEN;

  list_word_t   acc_word;
  list_result_t model_res;
  list_result_t got_res;
  list_result_t exp_res;

  cursor_linked_list_manager #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic bit is_node_slot(logic [4:0] idx);
    return (idx >= 1) && (idx <= SLOTS - 2);
  endfunction

  function automatic void clear_list_store();
    for (int i = 0; i < SLOTS; i++) begin
      slot_value[i] = '0;
      slot_link[i]  = (i + 2 < SLOTS) ? 5'(i + 1) : 5'd0;
    end
    slot_link[SLOTS-2] = '0;
    lst_head  = '0;
    lst_tail  = '0;
    lst_count = '0;
  endfunction

  function automatic list_result_t apply_list_op(logic op, logic [31:0] v);
    list_result_t r;
    logic [4:0]   slot;
    logic [4:0]   after;
    logic [4:0]   prev;
    logic [4:0]   cur;
    int           steps;
    r.status = ST_DONE;
    r.slot   = '0;
    if (op == OP_APPEND) begin
      slot = slot_link[0];
      if (!is_node_slot(slot)) begin
        r.status = ST_FULL;
      end else begin
        after = slot_link[slot];
        slot_link[0] = is_node_slot(after) ? after : 5'd0;
        slot_value[slot] = v;
        slot_link[slot]  = '0;
        if (lst_count == 0 || !is_node_slot(lst_tail)) lst_head = slot;
        else slot_link[lst_tail] = slot;
        lst_tail  = slot;
        lst_count = lst_count + 1;
        r.slot    = slot;
      end
    end else if (v == 32'd0) begin
      r.status = ST_IGNORED;
    end else begin
      prev  = '0;
      cur   = lst_head;
      steps = 0;
      while (is_node_slot(cur) && steps < SLOTS) begin
        if (slot_value[cur] == v) break;
        prev = cur;
        cur  = slot_link[cur];
        steps++;
      end
      if (!is_node_slot(cur) || steps >= SLOTS || lst_count == 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        after = is_node_slot(slot_link[cur]) ? slot_link[cur] : 5'd0;
        if (prev == 0) lst_head = after;
        else slot_link[prev] = after;
        if (cur == lst_tail) lst_tail = prev;
        lst_count = lst_count - 1;
        if (lst_count == 0) begin
          lst_head = '0;
          lst_tail = '0;
        end
        slot_value[cur] = '0;
        slot_link[cur]  = is_node_slot(slot_link[0]) ? slot_link[0] : 5'd0;
        slot_link[0]    = cur;
        r.slot          = cur;
      end
    end
    r.len = lst_count;
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [31:0] v, input bit known,
                         input logic [1:0] st, input logic [4:0] sl, input logic [4:0] ln);
    list_word_t w;
    w.op          = op;
    w.value       = v;
    w.known       = known;
    w.want.status = st;
    w.want.slot   = sl;
    w.want.len    = ln;
    directed_words.push_back(w);
  endtask

  // Offers one word and returns at the edge where it is taken.
  task automatic offer_word(input list_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    offered_words.push_back(w);
    s_tvalid <= 1'b1;
    s_tdata  <= w.value;
    s_tuser  <= w.op;
    n_sent++;
    if (n_sent == LONG_HOLD_AT) long_hold_req = 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Result checking and prediction at each accepted word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_res.status = m_tdata[1:0];
        got_res.slot   = m_tdata[6:2];
        got_res.len    = m_tdata[11:7];
        n_results++;
        if (want_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result word %h with nothing expected", $time, m_tdata);
        end else begin
          exp_res = want_results.pop_front();
          if (got_res.status !== exp_res.status) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: status expected %0d actual %0d", $time,
                       exp_res.status, got_res.status);
          end
          if (got_res.slot !== exp_res.slot) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: slot_index expected %0d actual %0d", $time,
                       exp_res.slot, got_res.slot);
          end
          if (got_res.len !== exp_res.len) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: list_length expected %0d actual %0d", $time,
                       exp_res.len, got_res.len);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        acc_word  = offered_words.pop_front();
        model_res = apply_list_op(acc_word.op, acc_word.value);
        want_results.push_back(acc_word.known ? acc_word.want : model_res);
      end
    end
  end

  // Receiver: stall patterns that change from stretch to stretch, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      m_tready       <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(10, 150);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_HALF:   m_tready <= $urandom_range(0, 1);
        RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
        default:   m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    list_word_t  w;
    phase_kind_t phase;
    int          phase_left;
    int          n_rand;
    int          idx;
    bit          found;
    logic [31:0] pool [6];

    clear_list_store();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty list, zero delete, extremes of the value, head and tail removal.
    add_row(OP_DELETE, 32'h0000_0005, 1'b1, ST_NOT_FOUND, 5'd0, 5'd0);
    add_row(OP_DELETE, 32'h0000_0000, 1'b1, ST_IGNORED,   5'd0, 5'd0);
    add_row(OP_APPEND, 32'h7FFF_FFFF, 1'b1, ST_DONE,      5'd1, 5'd1);
    add_row(OP_APPEND, 32'h8000_0000, 1'b1, ST_DONE,      5'd2, 5'd2);
    add_row(OP_APPEND, 32'hFFFF_FFFF, 1'b1, ST_DONE,      5'd3, 5'd3);
    add_row(OP_APPEND, 32'h0000_0001, 1'b1, ST_DONE,      5'd4, 5'd4);
    add_row(OP_DELETE, 32'h0000_0000, 1'b1, ST_IGNORED,   5'd0, 5'd4);
    add_row(OP_DELETE, 32'h1234_5678, 1'b1, ST_NOT_FOUND, 5'd0, 5'd4);
    add_row(OP_DELETE, 32'h7FFF_FFFF, 1'b1, ST_DONE,      5'd1, 5'd3);
    add_row(OP_DELETE, 32'h0000_0001, 1'b1, ST_DONE,      5'd4, 5'd2);
    add_row(OP_APPEND, 32'h5555_5555, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_APPEND, 32'hAAAA_AAAA, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'h8000_0000, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'hAAAA_AAAA, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'hFFFF_FFFF, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'h5555_5555, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'h5555_5555, 1'b1, ST_NOT_FOUND, 5'd0, 5'd0);
    add_row(OP_APPEND, 32'h0000_0002, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_APPEND, 32'h0000_0002, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'h0000_0002, 1'b0, ST_DONE,      5'd0, 5'd0);
    add_row(OP_DELETE, 32'h0000_0002, 1'b0, ST_DONE,      5'd0, 5'd0);
    foreach (directed_words[i]) offer_word(directed_words[i]);

    // Fill and drain phases push the store to full and back to empty. A zero node
    // can never be deleted, so zero appends are kept to the last stretch of the run.
    phase_left = 0;
    n_rand     = 0;
    phase      = PH_MIX;
    while (n_rand < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        phase      = phase_kind_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
        foreach (pool[i])
          pool[i] = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 15)) : ($urandom | 32'h1);
      end
      case (phase)
        PH_FILL:  w.op = ($urandom_range(0, 99) < 85) ? OP_APPEND : OP_DELETE;
        PH_DRAIN: w.op = ($urandom_range(0, 99) < 15) ? OP_APPEND : OP_DELETE;
        default:  w.op = ($urandom_range(0, 99) < 50) ? OP_APPEND : OP_DELETE;
      endcase
      if (w.op == OP_APPEND) begin
        w.value = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 5)] : $urandom;
        if (w.value == 32'd0) w.value = 32'h1;
        if (n_rand >= ZERO_TAIL_AT && $urandom_range(0, 9) == 0) w.value = 32'd0;
      end else begin
        idx = $urandom_range(0, 99);
        if (idx < 70) begin
          // Pick a value that is live in the list, where one can be found quickly.
          found = 1'b0;
          for (int k = 0; k < 8 && !found; k++) begin
            idx = $urandom_range(1, SLOTS - 2);
            if (slot_value[idx] != 0) begin
              w.value = slot_value[idx];
              found   = 1'b1;
            end
          end
          if (!found) w.value = pool[$urandom_range(0, 5)];
        end else if (idx < 85) begin
          w.value = pool[$urandom_range(0, 5)];
        end else if (idx < 95) begin
          w.value = $urandom;
        end else begin
          w.value = 32'd0;
        end
      end
      w.known = 1'b0;
      w.want  = '0;
      offer_word(w);
      n_rand++;
      phase_left--;
    end
    s_tvalid <= 1'b0;

    while (n_results < n_sent) @(posedge clk);
    repeat (2 * SLOTS + 16) @(posedge clk);
    if (want_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, want_results.size());
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/clm_pkg.sv
hdl/clm_ctrl.sv
hdl/clm_dpath.sv
hdl/cursor_linked_list_manager.sv
tb/cursor_linked_list_manager_tb.sv
